### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the deframer; compiled out when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define HLPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication whose consequent is checked in the cycle after the antecedent.
`define HLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HLPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define HLPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### design/hlpd_pkg.sv
// ----------------------------------------------------------------------------
// hlpd_pkg
// Types and constants shared by the header/length packet deframer modules.
// ----------------------------------------------------------------------------
package hlpd_pkg;

    localparam int FRAME_DEPTH = 32;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int BYTE_W      = 8;
    localparam int MAXLEN_W    = 6;
    localparam int CMP_W       = (CNT_W > MAXLEN_W) ? CNT_W : MAXLEN_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [BYTE_W-1:0]   RST_HEADER_FIRST  = 8'd170;
    localparam logic [BYTE_W-1:0]   RST_HEADER_SECOND = 8'd85;
    localparam logic [BYTE_W-1:0]   RST_SET_COMMAND   = 8'd1;
    localparam logic [MAXLEN_W-1:0] RST_MAX_LENGTH    = 6'd24;

    // Smallest legal frame length: two header bytes plus the length byte.
    localparam logic [BYTE_W-1:0]   MIN_FRAME_LEN     = 8'd3;
    localparam logic [BYTE_W-1:0]   CMD_FRAME_LEN     = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER_FIRST  = 2'd0,
        CFG_HEADER_SECOND = 2'd1,
        CFG_SET_COMMAND   = 2'd2,
        CFG_MAX_LENGTH    = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   header_first;
        logic [BYTE_W-1:0]   header_second;
        logic [BYTE_W-1:0]   set_command_code;
        logic [MAXLEN_W-1:0] max_length;
    } cfg_t;

    // Store write from the receive side.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_req_t;

    // Frame completion handed to the readout side.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
        logic             set_command;
    } frame_done_t;

    typedef enum logic {
        RD_IDLE,
        RD_SEND
    } rd_state_t;

endpackage

### design/hlpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// hlpd_cfg_regs
// Configuration register file written through the index/data write channel.
// ----------------------------------------------------------------------------
module hlpd_cfg_regs
    import hlpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_HEADER_FIRST:  cfg_next.header_first     = cfg_data;
                CFG_HEADER_SECOND: cfg_next.header_second    = cfg_data;
                CFG_SET_COMMAND:   cfg_next.set_command_code = cfg_data;
                CFG_MAX_LENGTH:    cfg_next.max_length       = cfg_data[MAXLEN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_first     <= RST_HEADER_FIRST;
            cfg_reg.header_second    <= RST_HEADER_SECOND;
            cfg_reg.set_command_code <= RST_SET_COMMAND;
            cfg_reg.max_length       <= RST_MAX_LENGTH;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/hlpd_rx_ctrl.sv
// ----------------------------------------------------------------------------
// hlpd_rx_ctrl
// Receive-side framing: counts bytes, checks the headers and the length,
// writes every byte into the frame store and signals a completed frame.
// ----------------------------------------------------------------------------
module hlpd_rx_ctrl
    import hlpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              rx_accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output wr_req_t           wr_req,
    output frame_done_t       done
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [BYTE_W-1:0] len_reg;
    logic [BYTE_W-1:0] len_next;
    logic [BYTE_W-1:0] cmd_reg;
    logic [BYTE_W-1:0] cmd_next;

    logic [CNT_W-1:0]  new_count;
    logic [CMP_W-1:0]  new_count_cmp;
    logic [CMP_W-1:0]  max_cmp;
    logic [CMP_W-1:0]  limit;
    logic [BYTE_W-1:0] new_count_b;
    logic [BYTE_W-1:0] len_eff;
    logic [BYTE_W-1:0] cmd_eff;
    logic              drop;
    logic              complete;

    assign new_count     = count_reg + CNT_W'(1);
    assign new_count_cmp = CMP_W'(new_count);
    assign new_count_b   = BYTE_W'(new_count);
    assign max_cmp       = CMP_W'(cfg.max_length);
    assign limit         = (max_cmp > CMP_W'(FRAME_DEPTH)) ? CMP_W'(FRAME_DEPTH) : max_cmp;

    // The length and command bytes are taken from the incoming word on the
    // cycle they arrive, and from the captured copies afterwards.
    assign len_eff = (new_count_b == MIN_FRAME_LEN) ? rx_byte : len_reg;
    assign cmd_eff = (new_count_b == CMD_FRAME_LEN) ? rx_byte : cmd_reg;

    always_comb begin
        drop     = 1'b0;
        complete = 1'b0;
        if (new_count_cmp >= limit) begin
            drop = 1'b1;
        end else if (new_count_b == 8'd1) begin
            drop = (rx_byte != cfg.header_first);
        end else if (new_count_b == 8'd2) begin
            drop = (rx_byte != cfg.header_second);
        end else if (len_eff < MIN_FRAME_LEN) begin
            drop = 1'b1;
        end else begin
            complete = (new_count_b == len_eff);
        end
    end

    always_comb begin
        count_next = count_reg;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        if (rx_accept) begin
            count_next = (drop || complete) ? '0 : new_count;
            len_next   = len_eff;
            cmd_next   = cmd_eff;
        end
    end

    assign wr_req.en   = rx_accept;
    assign wr_req.addr = count_reg[ADDR_W-1:0];
    assign wr_req.data = rx_byte;

    assign done.start       = rx_accept && complete;
    assign done.len         = len_eff[CNT_W-1:0];
    assign done.set_command = (len_eff >= CMD_FRAME_LEN) && (cmd_eff == cfg.set_command_code);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg <= len_next;
        cmd_reg <= cmd_next;
    end

endmodule

### design/hlpd_frame_buf.sv
// ----------------------------------------------------------------------------
// hlpd_frame_buf
// Frame store and readout: a memory with a registered read port, a read
// sequencer and a two-stage output pipeline that streams a completed frame.
// ----------------------------------------------------------------------------
module hlpd_frame_buf
    import hlpd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  wr_req_t           wr_req,
    input  frame_done_t       done,
    output logic              busy,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [BYTE_W-1:0] out_byte,
    output logic              out_last,
    output logic              out_set_command
);

    logic [BYTE_W-1:0] frame_mem [FRAME_DEPTH];

    rd_state_t         state_reg;
    rd_state_t         state_next;
    logic [CNT_W-1:0]  addr_reg;
    logic [CNT_W-1:0]  addr_next;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  len_next;
    logic              setc_reg;
    logic              setc_next;

    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [BYTE_W-1:0] rd_data_reg;
    logic              rd_last_reg;
    logic              rd_setc_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_last_reg;
    logic              out_setc_reg;

    logic              issue;
    logic              issue_last;
    logic              out_load;

    assign out_load   = rd_valid_reg && (!out_valid_reg || out_ready);
    assign issue      = (state_reg == RD_SEND) && (!rd_valid_reg || out_load);
    assign issue_last = (addr_reg + CNT_W'(1)) == len_reg;

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        len_next   = len_reg;
        setc_next  = setc_reg;
        case (state_reg)
            RD_IDLE: begin
                if (done.start) begin
                    state_next = RD_SEND;
                    addr_next  = '0;
                    len_next   = done.len;
                    setc_next  = done.set_command;
                end
            end
            RD_SEND: begin
                if (issue) begin
                    addr_next = addr_reg + CNT_W'(1);
                    if (issue_last) begin
                        state_next = RD_IDLE;
                    end
                end
            end
            default: state_next = RD_IDLE;
        endcase
    end

    always_comb begin
        rd_valid_next = rd_valid_reg;
        if (issue) begin
            rd_valid_next = 1'b1;
        end else if (out_load) begin
            rd_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Receive writes and readout reads never target the store in the same
    // cycle: input is held off while a frame is being read.
    always_ff @(posedge aclk) begin
        if (wr_req.en) begin
            frame_mem[wr_req.addr] <= wr_req.data;
        end
        if (issue) begin
            rd_data_reg <= frame_mem[addr_reg[ADDR_W-1:0]];
            rd_last_reg <= issue_last;
            rd_setc_reg <= setc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_byte_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_setc_reg <= rd_setc_reg;
        end
        addr_reg <= addr_next;
        len_reg  <= len_next;
        setc_reg <= setc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= RD_IDLE;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign busy            = (state_reg == RD_SEND);
    assign out_valid       = out_valid_reg;
    assign out_byte        = out_byte_reg;
    assign out_last        = out_last_reg;
    assign out_set_command = out_setc_reg;

endmodule

### design/header_length_packet_deframer.sv
// ----------------------------------------------------------------------------
// header_length_packet_deframer
// Collects received bytes into frames delimited by two header bytes and a
// length byte, then streams each completed frame out byte by byte.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word contents
//  s_axis    in         tdata[7:0] = rx_byte
//  m_axis    out        tdata[7:0] = frame_byte, tlast = frame_last,
//                       tuser[0] = set_command
//  cfg       in         cfg_index selects the register, cfg_data the value
//
//  Input bytes are taken one per cycle while no frame is being read out.
//  The byte that completes a frame of length L starts a readout of its L bytes
//  at one byte per cycle while m_axis is ready, paced by the frame store's
//  single registered read port; s_axis_tready is low while the store is read.
//  A stalled m_axis holds the readout; the two output stages keep the word.
//  Reset is synchronous and active low; the frame store needs no clearing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module header_length_packet_deframer
    import hlpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] frame_byte
    output logic                 m_axis_tlast,
    output logic [0:0]           m_axis_tuser,   // [0] set_command

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t        cfg;
    wr_req_t     wr_req;
    frame_done_t done;
    logic        busy;
    logic        rx_accept;

    assign s_axis_tready = !busy;
    assign rx_accept     = s_axis_tvalid && s_axis_tready;

    hlpd_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hlpd_rx_ctrl u_rx_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .rx_accept (rx_accept),
        .rx_byte   (s_axis_tdata),
        .wr_req    (wr_req),
        .done      (done)
    );

    hlpd_frame_buf u_frame_buf (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr_req          (wr_req),
        .done            (done),
        .busy            (busy),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_byte        (m_axis_tdata),
        .out_last        (m_axis_tlast),
        .out_set_command (m_axis_tuser[0])
    );

    // A completed frame must stop the input on the next cycle.
    `HLPD_ASSERT_NEXT(a_done_blocks_input, aclk, aresetn, done.start, !s_axis_tready,
        "input not held off after frame completion")

    // A frame only completes with a length that fits the store and has a header.
    `HLPD_ASSERT(a_done_len_range, aclk, aresetn,
        !done.start || (done.len >= CNT_W'(3) && done.len < CNT_W'(FRAME_DEPTH)),
        "completed frame length out of range")

    // Store writes happen only for accepted input words.
    `HLPD_ASSERT(a_write_on_accept, aclk, aresetn, wr_req.en == (s_axis_tvalid && !busy),
        "store write without accepted input")

endmodule

### verif/header_length_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_length_packet_deframer_tb
// Feeds received bytes into the deframer with random gaps on the input side
// and random stalls on the output side, predicts every frame word it should
// emit, and checks each output word against the oldest prediction. A short
// table of hand-written bytes comes first, then phases of random frames,
// broken frames and noise under several register settings.
// ----------------------------------------------------------------------------
module header_length_packet_deframer_tb;
    import hlpd_pkg::*;

    localparam int          USE_MODEL     = -1;
    localparam int          NO_WORDS      = 0;
    localparam int          SETTLE_CYCLES = 16;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int          NUM_PHASES    = 6;
    localparam int          REPORT_MAX    = 10;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       setc;
    } out_word_t;

    // One directed byte; typed_n gives the hand-written word count it causes,
    // or USE_MODEL when the predictor supplies the expected words.
    typedef struct packed {
        logic [7:0]        rx;
        logic signed [7:0] typed_n;
        logic              typed_setc;
    } dir_row_t;

    localparam int DIR_ROWS = 21;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Shortest frame right after reset: no command byte.
        '{8'hAA, NO_WORDS, 1'b0}, '{8'h55, NO_WORDS, 1'b0}, '{8'h03, 3, 1'b0},
        // Wrong first header byte.
        '{8'h00, NO_WORDS, 1'b0},
        // Wrong second header byte.
        '{8'hAA, NO_WORDS, 1'b0}, '{8'h00, NO_WORDS, 1'b0},
        // Length below three is dropped when the length byte arrives.
        '{8'hAA, NO_WORDS, 1'b0}, '{8'h55, NO_WORDS, 1'b0}, '{8'h02, NO_WORDS, 1'b0},
        '{8'hAA, NO_WORDS, 1'b0}, '{8'h55, NO_WORDS, 1'b0}, '{8'h00, NO_WORDS, 1'b0},
        // Set-command frame.
        '{8'hAA, USE_MODEL, 1'b0}, '{8'h55, USE_MODEL, 1'b0},
        '{8'h04, USE_MODEL, 1'b0}, '{8'h01, USE_MODEL, 1'b0},
        // Command byte that does not match, extreme data values.
        '{8'hAA, USE_MODEL, 1'b0}, '{8'h55, USE_MODEL, 1'b0},
        '{8'h05, USE_MODEL, 1'b0}, '{8'hFF, USE_MODEL, 1'b0}, '{8'h80, USE_MODEL, 1'b0}
    };

    logic             aclk;
    logic             aresetn       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;   // [7:0] rx_byte
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [7:0]       m_axis_tdata;         // [7:0] frame_byte
    logic             m_axis_tlast;
    logic [0:0]       m_axis_tuser;         // [0] set_command
    logic             cfg_valid     = 1'b0;
    logic             cfg_ready;
    cfg_index_t       cfg_index     = CFG_HEADER_FIRST;
    logic [7:0]       cfg_data      = '0;

    header_length_packet_deframer dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Shadow of the block's registers and frame state.
    cfg_t        shadow_cfg;
    logic [7:0]  frame_copy [FRAME_DEPTH];
    int unsigned fill_count;
    out_word_t   burst [FRAME_DEPTH];

    out_word_t   expected_words [$];
    int          failures = 0;
    int          bytes_sent = 0;
    bit          src_steady = 1'b0;
    bit          sink_steady = 1'b0;
    int          sink_hold = 0;
    int unsigned cycle_count = 0;

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= REPORT_MAX)
            $display("%s", msg);
    endfunction

    function automatic int unsigned frame_limit();
        int unsigned lim;
        lim = int'(shadow_cfg.max_length);
        if (lim > FRAME_DEPTH)
            lim = FRAME_DEPTH;
        return lim;
    endfunction

    // Stores one received byte and returns the number of frame words it
    // releases into burst.
    function automatic int deframe_byte(input logic [7:0] b);
        int unsigned lim;
        int unsigned len;
        logic        setc;
        lim = frame_limit();
        if (fill_count < FRAME_DEPTH)
            frame_copy[fill_count] = b;
        fill_count++;
        // The limit check comes first, so a length at or above it never completes.
        if (fill_count >= lim) begin
            fill_count = 0;
            return 0;
        end
        if ((fill_count == 1 && b != shadow_cfg.header_first) ||
            (fill_count == 2 && b != shadow_cfg.header_second)) begin
            fill_count = 0;
            return 0;
        end
        if (fill_count < 3)
            return 0;
        len = frame_copy[2];
        if (len < MIN_FRAME_LEN) begin
            fill_count = 0;
            return 0;
        end
        if (fill_count != len)
            return 0;
        setc = (len >= CMD_FRAME_LEN) && (frame_copy[3] == shadow_cfg.set_command_code);
        for (int k = 0; k < len; k++)
            burst[k] = '{data: frame_copy[k], last: (k == len - 1), setc: setc};
        fill_count = 0;
        return len;
    endfunction

    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 49) == 0)
            src_steady = !src_steady;
        if (src_steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Returns at the edge where the byte is taken; tvalid stays high so the
    // next call can follow without a gap.
    task automatic push_byte(input logic [7:0] b, input bit use_model);
        int gap;
        int n;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        n = deframe_byte(b);
        if (use_model)
            for (int k = 0; k < n; k++)
                expected_words.push_back(burst[k]);
    endtask

    // Brings the frame state back to an empty count.
    task automatic drain_frame();
        logic [7:0] b;
        while (fill_count != 0) begin
            if (fill_count == 1)
                b = ~shadow_cfg.header_second;
            else if (fill_count == 2)
                b = 8'h00;
            else
                b = 8'($urandom);
            push_byte(b, 1'b1);
        end
    endtask

    task automatic send_group();
        int r;
        int lim;
        int hi;
        int len;
        lim = frame_limit();
        r = $urandom_range(0, 99);
        if (r < 70) begin
            drain_frame();
            hi = (lim > 3) ? lim - 1 : 6;
            if ($urandom_range(0, 9) != 0 && hi > 10)
                hi = 10;
            len = $urandom_range(3, hi);
            push_byte(shadow_cfg.header_first, 1'b1);
            push_byte(shadow_cfg.header_second, 1'b1);
            push_byte(8'(len), 1'b1);
            if (len >= 4)
                push_byte($urandom_range(0, 1) ? shadow_cfg.set_command_code : 8'($urandom),
                          1'b1);
            for (int k = 4; k < len; k++)
                push_byte(8'($urandom), 1'b1);
        end else if (r < 80) begin
            // Length at or past the limit: the frame must be discarded.
            len = ($urandom_range(0, 3) == 0) ? 255 : lim + $urandom_range(0, 3);
            push_byte(shadow_cfg.header_first, 1'b1);
            push_byte(shadow_cfg.header_second, 1'b1);
            push_byte(8'(len), 1'b1);
            repeat (lim) push_byte(8'($urandom), 1'b1);
        end else if (r < 90) begin
            case ($urandom_range(0, 2))
                0: begin
                    push_byte(shadow_cfg.header_first, 1'b1);
                    push_byte(8'($urandom), 1'b1);
                end
                1: begin
                    push_byte(shadow_cfg.header_first, 1'b1);
                    push_byte(shadow_cfg.header_second, 1'b1);
                    push_byte(8'($urandom_range(0, 2)), 1'b1);
                end
                default: push_byte(8'($urandom), 1'b1);
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b1);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HEADER_FIRST:  shadow_cfg.header_first     = val;
            CFG_HEADER_SECOND: shadow_cfg.header_second    = val;
            CFG_SET_COMMAND:   shadow_cfg.set_command_code = val;
            CFG_MAX_LENGTH:    shadow_cfg.max_length       = val[MAXLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every predicted word has come out and the block has settled.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Output side: check each accepted word, then choose the next ready value.
    always @(posedge aclk) begin : sink
        out_word_t want;
        int        r;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                note_failure($sformatf("unexpected word: data %02h last %0b setc %0b",
                                       m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
            end else begin
                want = expected_words.pop_front();
                if (m_axis_tdata !== want.data || m_axis_tlast !== want.last ||
                    m_axis_tuser[0] !== want.setc)
                    note_failure($sformatf(
                        "mismatch: expected data %02h last %0b setc %0b, got %02h %0b %0b",
                        want.data, want.last, want.setc,
                        m_axis_tdata, m_axis_tlast, m_axis_tuser[0]));
            end
        end
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else begin
            if ($urandom_range(0, 19) == 0)
                sink_steady <= !sink_steady;
            r = $urandom_range(0, 99);
            if (sink_steady) begin
                m_axis_tready <= 1'b1;
                sink_hold     <= $urandom_range(20, 60);
            end else if (r < 55) begin
                m_axis_tready <= 1'b1;
                sink_hold     <= $urandom_range(0, 5);
            end else if (r < 93) begin
                m_axis_tready <= 1'b0;
                sink_hold     <= $urandom_range(0, 2);
            end else if (r < 98) begin
                m_axis_tready <= 1'b0;
                sink_hold     <= $urandom_range(8, 15);
            end else begin
                m_axis_tready <= 1'b0;
                sink_hold     <= $urandom_range(20, 40);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL header_length_packet_deframer");
            $finish;
        end
    end

    initial begin : main
        int         budget;
        int         start_count;
        int         n;
        logic [7:0] hf;
        logic [7:0] hs;
        logic [7:0] cmd;
        logic [5:0] ml;

        shadow_cfg = '{header_first: RST_HEADER_FIRST, header_second: RST_HEADER_SECOND,
                       set_command_code: RST_SET_COMMAND, max_length: RST_MAX_LENGTH};
        fill_count = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed bytes under the reset register values.
        for (int i = 0; i < DIR_ROWS; i++) begin
            push_byte(DIRECTED[i].rx, DIRECTED[i].typed_n == USE_MODEL);
            n = DIRECTED[i].typed_n;
            for (int k = 0; k < n; k++)
                expected_words.push_back('{data: DIRECTED[i - n + 1 + k].rx,
                                           last: (k == n - 1),
                                           setc: DIRECTED[i].typed_setc});
        end
        drain_frame();
        wait_quiet();

        for (int p = 0; p < NUM_PHASES; p++) begin
            hf  = 8'($urandom);
            hs  = 8'($urandom);
            cmd = 8'($urandom);
            case (p)
                0: begin
                    ml = 6'd32;
                    budget = 20;
                end
                1: begin
                    hf = 8'h00; hs = 8'hFF; cmd = 8'h00; ml = 6'd4;
                    budget = 15;
                end
                2: begin
                    hf = 8'hFF; hs = 8'h00; cmd = 8'hFF; ml = 6'd63;
                    budget = 25;
                end
                3: begin
                    ml = 6'($urandom_range(4, 32));
                    budget = 15;
                end
                4: begin
                    // Limit too small for any frame to complete.
                    ml = 6'($urandom_range(0, 3));
                    budget = 10;
                end
                default: begin
                    hf = RST_HEADER_FIRST; hs = RST_HEADER_SECOND; cmd = RST_SET_COMMAND;
                    ml = 6'($urandom_range(5, 20));
                    budget = 20;
                end
            endcase
            write_reg(CFG_HEADER_FIRST, hf);
            write_reg(CFG_HEADER_SECOND, hs);
            write_reg(CFG_SET_COMMAND, cmd);
            write_reg(CFG_MAX_LENGTH, {2'b00, ml});
            cfg_valid <= 1'b0;

            start_count = bytes_sent;
            while (bytes_sent - start_count < budget)
                send_group();
            drain_frame();
            wait_quiet();
        end

        if (expected_words.size() != 0)
            note_failure($sformatf("%0d expected words never came out",
                                   expected_words.size()));
        if (failures == 0)
            $display("PASS header_length_packet_deframer");
        else
            $display("FAIL header_length_packet_deframer");
        $finish;
    end

endmodule
